FILE: hdl/named_lock_table_macros.svh
// ----------------------------------------------------------------------------
// named_lock_table_macros
// Assertion macros used by the lock table sequencer, nlt_ctrl.
// ----------------------------------------------------------------------------
`ifndef NAMED_LOCK_TABLE_MACROS_SVH
`define NAMED_LOCK_TABLE_MACROS_SVH

// Condition in this cycle implies consequence in the same cycle.
`define NLT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lock table assertion failed");

// Condition in this cycle implies consequence in the next cycle.
`define NLT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lock table assertion failed");

`endif

FILE: hdl/nlt_pkg.sv
// ----------------------------------------------------------------------------
// nlt_pkg
// Shared codes, widths and the token that travels along the cell chain.
// ----------------------------------------------------------------------------
package nlt_pkg;

    localparam int ENTRIES_DEF  = 16;
    localparam int KEY_BITS_DEF = 64;

    localparam int OPCODE_W = 3;
    localparam int KEY_W    = 64;
    localparam int CLIENT_W = 22;
    localparam int STATUS_W = 4;
    localparam int COUNT_W  = 5;

    localparam logic [OPCODE_W-1:0] OP_CREATE = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_LOCK   = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_UNLOCK = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_DELETE = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_PERM   = 3'd4;
    localparam logic [OPCODE_W-1:0] OP_SEND   = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK           = 4'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY        = 4'd1;
    localparam logic [STATUS_W-1:0] ST_FULL         = 4'd2;
    localparam logic [STATUS_W-1:0] ST_EXISTS       = 4'd3;
    localparam logic [STATUS_W-1:0] ST_OTHER_HOLDS  = 4'd4;
    localparam logic [STATUS_W-1:0] ST_ALREADY_MINE = 4'd5;
    localparam logic [STATUS_W-1:0] ST_LOCKED_OTHER = 4'd6;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND    = 4'd7;
    localparam logic [STATUS_W-1:0] ST_NOT_LOCKED   = 4'd8;
    localparam logic [STATUS_W-1:0] ST_NOT_OWNER    = 4'd9;

    localparam int ACT_W = 3;
    localparam logic [ACT_W-1:0] ACT_NONE   = 3'd0;
    localparam logic [ACT_W-1:0] ACT_CREATE = 3'd1;
    localparam logic [ACT_W-1:0] ACT_LOCK   = 3'd2;
    localparam logic [ACT_W-1:0] ACT_UNLOCK = 3'd3;
    localparam logic [ACT_W-1:0] ACT_DELETE = 3'd4;

    // Token handed from cell to cell; flags gather on the scan pass,
    // action is carried out on the apply pass.
    typedef struct packed {
        logic                valid;
        logic                apply;
        logic [ACT_W-1:0]    action;
        logic [CLIENT_W-1:0] client;
        logic                found;
        logic                found_locked;
        logic                found_own;
        logic                other_locked;
        logic                done;
    } tok_t;

endpackage

FILE: hdl/nlt_req_if.sv
// ----------------------------------------------------------------------------
// nlt_req_if
// Request channel: opcode, name key and client id with valid/ready.
// ----------------------------------------------------------------------------
interface nlt_req_if;
    logic                           valid;
    logic                           ready;
    logic [nlt_pkg::OPCODE_W-1:0]   opcode;
    logic [nlt_pkg::KEY_W-1:0]      name_key;
    logic [nlt_pkg::CLIENT_W-1:0]   client_id;

    modport source (output valid, output opcode, output name_key, output client_id,
                    input ready);
    modport sink   (input valid, input opcode, input name_key, input client_id,
                    output ready);
endinterface

FILE: hdl/nlt_rsp_if.sv
// ----------------------------------------------------------------------------
// nlt_rsp_if
// Response channel: status, permission bit and entry count with valid/ready.
// ----------------------------------------------------------------------------
interface nlt_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [nlt_pkg::STATUS_W-1:0]   status;
    logic                           permitted;
    logic [nlt_pkg::COUNT_W-1:0]    entry_count;

    modport source (output valid, output status, output permitted, output entry_count,
                    input ready);
    modport sink   (input valid, input status, input permitted, input entry_count,
                    output ready);
endinterface

FILE: hdl/nlt_cell.sv
// ----------------------------------------------------------------------------
// nlt_cell
// One table entry plus one stage of the token chain.
// ----------------------------------------------------------------------------
module nlt_cell #(
    parameter int KEY_BITS = nlt_pkg::KEY_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  nlt_pkg::tok_t       tok_in,
    input  logic [KEY_BITS-1:0] key_in,
    output nlt_pkg::tok_t       tok_out,
    output logic [KEY_BITS-1:0] key_out
);

    logic                         valid_reg, valid_next;
    logic                         locked_reg, locked_next;
    logic [KEY_BITS-1:0]          key_reg, key_next;
    logic [nlt_pkg::CLIENT_W-1:0] owner_reg, owner_next;
    nlt_pkg::tok_t                tok_reg, tok_next;
    logic [KEY_BITS-1:0]          kout_reg;
    logic                         match;
    logic                         own;

    assign match = valid_reg && (key_reg == key_in);
    assign own   = (owner_reg == tok_in.client);

    always_comb
    begin
        tok_next    = tok_in;
        valid_next  = valid_reg;
        locked_next = locked_reg;
        key_next    = key_reg;
        owner_next  = owner_reg;
        if (tok_in.valid)
        begin
            if (!tok_in.apply)
            begin
                tok_next.found        = tok_in.found | match;
                tok_next.found_locked = tok_in.found_locked | (match & locked_reg);
                tok_next.found_own    = tok_in.found_own | (match & own);
                tok_next.other_locked = tok_in.other_locked
                                        | (valid_reg & locked_reg & !own);
            end
            else
            begin
                case (tok_in.action)
                    nlt_pkg::ACT_CREATE:
                    begin
                        // first free cell takes the new entry
                        if (!valid_reg && !tok_in.done)
                        begin
                            valid_next    = 1'b1;
                            locked_next   = 1'b0;
                            key_next      = key_in;
                            owner_next    = tok_in.client;
                            tok_next.done = 1'b1;
                        end
                    end
                    nlt_pkg::ACT_LOCK:
                    begin
                        if (match)
                        begin
                            locked_next = 1'b1;
                            owner_next  = tok_in.client;
                        end
                    end
                    nlt_pkg::ACT_UNLOCK:
                    begin
                        if (match)
                            locked_next = 1'b0;
                    end
                    nlt_pkg::ACT_DELETE:
                    begin
                        if (match)
                        begin
                            valid_next  = 1'b0;
                            locked_next = 1'b0;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            locked_reg <= 1'b0;
            tok_reg    <= '0;
        end
        else
        begin
            valid_reg  <= valid_next;
            locked_reg <= locked_next;
            tok_reg    <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        owner_reg <= owner_next;
        kout_reg  <= key_in;
    end

    assign tok_out = tok_reg;
    assign key_out = kout_reg;

endmodule

FILE: hdl/nlt_ctrl.sv
// ----------------------------------------------------------------------------
// nlt_ctrl
// Request sequencer: launches scan and apply tokens, decides the outcome.
// ----------------------------------------------------------------------------
`include "named_lock_table_macros.svh"

module nlt_ctrl #(
    parameter int ENTRIES  = nlt_pkg::ENTRIES_DEF,
    parameter int KEY_BITS = nlt_pkg::KEY_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    nlt_req_if.sink             req,
    nlt_rsp_if.source           rsp,
    output nlt_pkg::tok_t       head_tok,
    output logic [KEY_BITS-1:0] head_key,
    input  nlt_pkg::tok_t       tail_tok
);

    localparam int CNT_W = $clog2(ENTRIES + 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_APPLY = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]                   state_reg, state_next;
    logic [CNT_W-1:0]             count_reg, count_next;
    logic [nlt_pkg::OPCODE_W-1:0] op_reg;
    logic [KEY_BITS-1:0]          key_reg;
    logic [nlt_pkg::CLIENT_W-1:0] client_reg;
    logic [nlt_pkg::STATUS_W-1:0] status_reg, status_next;
    logic                         perm_reg, perm_next;
    logic                         out_valid_reg, out_valid_next;
    logic [nlt_pkg::STATUS_W-1:0] out_status_reg;
    logic                         out_perm_reg;
    logic [CNT_W-1:0]             out_count_reg;
    logic                         in_fire;
    logic                         scan_end;
    logic                         apply_end;
    logic                         out_load;
    logic [nlt_pkg::ACT_W-1:0]    action;
    logic                         full;

    assign req.ready = (state_reg == S_IDLE);
    assign in_fire   = req.valid && req.ready;
    assign scan_end  = (state_reg == S_SCAN) && tail_tok.valid && !tail_tok.apply;
    assign apply_end = (state_reg == S_APPLY) && tail_tok.valid && tail_tok.apply;
    assign out_load  = (state_reg == S_DONE) && (!out_valid_reg || rsp.ready);
    assign full      = (count_reg >= CNT_W'(ENTRIES));

    // Decide the outcome from the flags gathered on the scan pass.
    always_comb
    begin
        status_next = nlt_pkg::ST_OK;
        perm_next   = 1'b0;
        action      = nlt_pkg::ACT_NONE;
        count_next  = count_reg;
        case (op_reg)
            nlt_pkg::OP_CREATE:
            begin
                if (key_reg == '0)
                    status_next = nlt_pkg::ST_EMPTY;
                else if (full)
                    status_next = nlt_pkg::ST_FULL;
                else if (tail_tok.found)
                    status_next = nlt_pkg::ST_EXISTS;
                else
                begin
                    action     = nlt_pkg::ACT_CREATE;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            nlt_pkg::OP_LOCK:
            begin
                if (tail_tok.other_locked)
                    status_next = nlt_pkg::ST_OTHER_HOLDS;
                else if (!tail_tok.found)
                    status_next = nlt_pkg::ST_NOT_FOUND;
                else if (tail_tok.found_locked)
                    status_next = tail_tok.found_own ? nlt_pkg::ST_ALREADY_MINE
                                                     : nlt_pkg::ST_LOCKED_OTHER;
                else
                    action = nlt_pkg::ACT_LOCK;
            end
            nlt_pkg::OP_UNLOCK:
            begin
                if (!tail_tok.found)
                    status_next = nlt_pkg::ST_NOT_FOUND;
                else if (!tail_tok.found_locked)
                    status_next = nlt_pkg::ST_NOT_LOCKED;
                else if (!tail_tok.found_own)
                    status_next = nlt_pkg::ST_NOT_OWNER;
                else
                    action = nlt_pkg::ACT_UNLOCK;
            end
            nlt_pkg::OP_DELETE:
            begin
                if (!tail_tok.found)
                    status_next = nlt_pkg::ST_NOT_FOUND;
                else if (tail_tok.found_locked && !tail_tok.found_own)
                    status_next = nlt_pkg::ST_LOCKED_OTHER;
                else
                begin
                    action = nlt_pkg::ACT_DELETE;
                    if (count_reg != '0)
                        count_next = count_reg - CNT_W'(1);
                end
            end
            nlt_pkg::OP_PERM:
            begin
                if (!tail_tok.found)
                    status_next = nlt_pkg::ST_NOT_FOUND;
                else
                    perm_next = !tail_tok.found_locked || tail_tok.found_own;
            end
            nlt_pkg::OP_SEND:
            begin
                if (!tail_tok.found)
                    status_next = nlt_pkg::ST_NOT_FOUND;
                else if (!tail_tok.found_locked || !tail_tok.found_own)
                    status_next = nlt_pkg::ST_NOT_OWNER;
            end
            default:
            begin
            end
        endcase
    end

    // Head of the chain: scan token on accept, apply token when the scan exits.
    always_comb
    begin
        head_tok = '0;
        head_key = key_reg;
        if (in_fire)
        begin
            head_tok.valid  = 1'b1;
            head_tok.client = req.client_id;
            head_key        = req.name_key[KEY_BITS-1:0];
        end
        else if (scan_end)
        begin
            head_tok.valid  = 1'b1;
            head_tok.apply  = 1'b1;
            head_tok.action = action;
            head_tok.client = client_reg;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (in_fire)   state_next = S_SCAN;
            S_SCAN:  if (scan_end)  state_next = S_APPLY;
            S_APPLY: if (apply_end) state_next = S_DONE;
            S_DONE:  if (out_load)  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (rsp.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (scan_end)
                count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_reg     <= req.opcode;
            key_reg    <= req.name_key[KEY_BITS-1:0];
            client_reg <= req.client_id;
        end
        if (scan_end)
        begin
            status_reg <= status_next;
            perm_reg   <= perm_next;
        end
        if (out_load)
        begin
            out_status_reg <= status_reg;
            out_perm_reg   <= perm_reg;
            out_count_reg  <= count_reg;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.permitted   = out_perm_reg;
    assign rsp.entry_count = nlt_pkg::COUNT_W'(out_count_reg);

    `NLT_ASSERT_IMPL(a_count_range, clk, rst_n, 1'b1, count_reg <= CNT_W'(ENTRIES))
    `NLT_ASSERT_NEXT(a_accept_scan, clk, rst_n, in_fire, state_reg == S_SCAN)
    `NLT_ASSERT_IMPL(a_tail_busy, clk, rst_n, tail_tok.valid,
                     state_reg == S_SCAN || state_reg == S_APPLY)
    `NLT_ASSERT_IMPL(a_done_quiet, clk, rst_n, state_reg == S_DONE, !tail_tok.valid)

endmodule

FILE: hdl/named_lock_table.sv
// ----------------------------------------------------------------------------
// named_lock_table
// Table of named locks built as a chain of entry cells.
// ----------------------------------------------------------------------------
// Requests arrive on req (opcode, name_key, client_id) and each produces one
// response on rsp (status, permitted, entry_count); both use valid/ready and
// a transfer happens when both are high.
// Each entry lives in one cell of a chain of ENTRIES cells. A request sends
// a scan token down the chain, one cell per cycle, gathering match and lock
// flags; the sequencer then decides the outcome and sends an apply token
// that performs the update in the owning or first free cell.
// A request passes the scan, apply and done states of the sequencer before
// its response is loaded into the response register; one request is in
// progress at a time, so req is ready again only once that load is done.
// The response register holds a finished result while the next request is
// taken; if rsp stalls, the following request completes its passes and then
// waits for the response register to free before req is ready again.
// Reset empties the table at once: all entries invalid and unlocked, count 0.
// ----------------------------------------------------------------------------
module named_lock_table #(
    parameter int ENTRIES  = nlt_pkg::ENTRIES_DEF,
    parameter int KEY_BITS = nlt_pkg::KEY_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    nlt_req_if.sink   req,
    nlt_rsp_if.source rsp
);

    nlt_pkg::tok_t       tok_w [ENTRIES+1];
    logic [KEY_BITS-1:0] key_w [ENTRIES+1];

    nlt_ctrl #(
        .ENTRIES  (ENTRIES),
        .KEY_BITS (KEY_BITS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .rsp      (rsp),
        .head_tok (tok_w[0]),
        .head_key (key_w[0]),
        .tail_tok (tok_w[ENTRIES])
    );

    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        nlt_cell #(
            .KEY_BITS (KEY_BITS)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .tok_in  (tok_w[i]),
            .key_in  (key_w[i]),
            .tok_out (tok_w[i+1]),
            .key_out (key_w[i+1])
        );
    end

endmodule

FILE: test/tb_named_lock_table.sv
// ----------------------------------------------------------------------------
// tb_named_lock_table
// Self-checking testbench for the named lock table.
// ----------------------------------------------------------------------------
// Drives create, lock, unlock, delete, permission and send requests into the
// table and checks every response against a cycle-free model of the table
// kept in the bench. Directed cases come first, then a full-table test, then
// random lock lifecycles mixed with noise. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_named_lock_table;
    timeunit 1ns;
    timeprecision 1ps;

    import nlt_pkg::*;

    localparam int ENTRIES  = ENTRIES_DEF;
    localparam int KEY_BITS = KEY_BITS_DEF;
    localparam logic [KEY_W-1:0] KEY_MASK = {KEY_W{1'b1}} >> (KEY_W - KEY_BITS);
    localparam int LATENCY  = 2 * ENTRIES + 2;

    // Opcodes with no function; the table must answer ok and change nothing.
    localparam logic [OPCODE_W-1:0] OP_SPARE_A = 3'd6;
    localparam logic [OPCODE_W-1:0] OP_SPARE_B = 3'd7;

    localparam logic [KEY_W-1:0]    KEY_ALL_ONES = {KEY_W{1'b1}};
    localparam logic [KEY_W-1:0]    KEY_ONE      = 64'd1;
    localparam logic [CLIENT_W-1:0] CLIENT_LOW   = '0;
    localparam logic [CLIENT_W-1:0] CLIENT_HIGH  = {CLIENT_W{1'b1}};

    localparam int NAME_POOL   = 24;
    localparam int CLIENT_POOL = 4;
    localparam int TARGET_ITEMS = 1650;

    typedef struct {
        logic [OPCODE_W-1:0] op;
        logic [STATUS_W-1:0] status;
        logic                permitted;
        logic [COUNT_W-1:0]  entry_count;
    } lock_answer_t;

    logic clk;
    logic rst_n;

    nlt_req_if req_if();
    nlt_rsp_if rsp_if();

    named_lock_table #(
        .ENTRIES  (ENTRIES),
        .KEY_BITS (KEY_BITS)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    // Bench copy of the table
    logic                tbl_valid  [ENTRIES];
    logic [KEY_W-1:0]    tbl_key    [ENTRIES];
    logic [CLIENT_W-1:0] tbl_owner  [ENTRIES];
    logic                tbl_locked [ENTRIES];
    int                  tbl_used;

    lock_answer_t        pending_answers[$];
    logic [KEY_W-1:0]    name_pool   [NAME_POOL];
    logic [CLIENT_W-1:0] client_pool [CLIENT_POOL];

    int   sent_count;
    int   checked_count;
    int   mismatch_count;
    int   status_hits [16];
    logic gaps_on;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #15ms;
        $display("Timeout: %0d requests sent, %0d responses checked, %0d pending",
                 sent_count, checked_count, pending_answers.size());
        $display("Some tests failed");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        if (mismatch_count < 30)
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        mismatch_count++;
    endtask

    function automatic int find_slot(input logic [KEY_W-1:0] key);
        for (int i = 0; i < ENTRIES; i++)
            if (tbl_valid[i] && tbl_key[i] == key)
                return i;
        return -1;
    endfunction

    // Work out the answer to one request and update the bench table.
    function automatic lock_answer_t predict_request(input logic [OPCODE_W-1:0] op,
                                                     input logic [KEY_W-1:0] key_in,
                                                     input logic [CLIENT_W-1:0] client);
        lock_answer_t ans;
        logic [KEY_W-1:0] key;
        int slot;
        ans.op = op;
        ans.status = ST_OK;
        ans.permitted = 1'b0;
        key = key_in & KEY_MASK;
        slot = find_slot(key);
        case (op)
            OP_CREATE:
                if (key == '0)
                    ans.status = ST_EMPTY;
                else if (tbl_used >= ENTRIES)
                    ans.status = ST_FULL;
                else if (slot >= 0)
                    ans.status = ST_EXISTS;
                else
                begin
                    for (int i = 0; i < ENTRIES; i++)
                        if (!tbl_valid[i] && slot < 0)
                            slot = i;
                    tbl_valid[slot] = 1'b1;
                    tbl_key[slot] = key;
                    tbl_owner[slot] = client;
                    tbl_locked[slot] = 1'b0;
                    tbl_used++;
                end
            OP_LOCK:
            begin
                for (int i = 0; i < ENTRIES; i++)
                    if (tbl_valid[i] && tbl_locked[i] && tbl_owner[i] != client)
                        ans.status = ST_OTHER_HOLDS;
                if (ans.status == ST_OK)
                begin
                    if (slot < 0)
                        ans.status = ST_NOT_FOUND;
                    else if (tbl_locked[slot])
                        ans.status = (tbl_owner[slot] == client) ? ST_ALREADY_MINE
                                                                 : ST_LOCKED_OTHER;
                    else
                    begin
                        tbl_locked[slot] = 1'b1;
                        tbl_owner[slot] = client;
                    end
                end
            end
            OP_UNLOCK:
                if (slot < 0)
                    ans.status = ST_NOT_FOUND;
                else if (!tbl_locked[slot])
                    ans.status = ST_NOT_LOCKED;
                else if (tbl_owner[slot] != client)
                    ans.status = ST_NOT_OWNER;
                else
                    tbl_locked[slot] = 1'b0;
            OP_DELETE:
                if (slot < 0)
                    ans.status = ST_NOT_FOUND;
                else if (tbl_locked[slot] && tbl_owner[slot] != client)
                    ans.status = ST_LOCKED_OTHER;
                else
                begin
                    tbl_valid[slot] = 1'b0;
                    tbl_locked[slot] = 1'b0;
                    if (tbl_used > 0)
                        tbl_used--;
                end
            OP_PERM:
                if (slot < 0)
                    ans.status = ST_NOT_FOUND;
                else
                    ans.permitted = !tbl_locked[slot] || tbl_owner[slot] == client;
            OP_SEND:
                if (slot < 0)
                    ans.status = ST_NOT_FOUND;
                else if (!tbl_locked[slot] || tbl_owner[slot] != client)
                    ans.status = ST_NOT_OWNER;
            default: ;
        endcase
        ans.entry_count = tbl_used[COUNT_W-1:0];
        return ans;
    endfunction

    function automatic int pick_gap();
        int r;
        if (!gaps_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    // Send one request and hold it until the transfer; record the answer.
    task automatic send_request(input logic [OPCODE_W-1:0] op,
                                input logic [KEY_W-1:0] key,
                                input logic [CLIENT_W-1:0] client);
        int gap;
        req_if.valid     <= 1'b1;
        req_if.opcode    <= op;
        req_if.name_key  <= key;
        req_if.client_id <= client;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        pending_answers.push_back(predict_request(op, key, client));
        sent_count++;
        gap = pick_gap();
        if (gap > 0)
        begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Drop valid and hold until every answer has come back.
    task automatic wait_drained();
        req_if.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_answers.size() != 0);
    endtask

    function automatic int pick_locked_slot();
        int start;
        int idx;
        start = $urandom_range(0, ENTRIES - 1);
        for (int i = 0; i < ENTRIES; i++)
        begin
            idx = (start + i) % ENTRIES;
            if (tbl_valid[idx] && tbl_locked[idx])
                return idx;
        end
        return -1;
    endfunction

    function automatic logic [KEY_W-1:0] pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return name_pool[$urandom_range(0, NAME_POOL - 1)];
        if (r < 92)
            return {$urandom, $urandom};
        return '0;
    endfunction

    function automatic logic [CLIENT_W-1:0] pick_client();
        if ($urandom_range(0, 99) < 85)
            return client_pool[$urandom_range(0, CLIENT_POOL - 1)];
        return CLIENT_W'($urandom);
    endfunction

    // Remove every entry, releasing locks through their owners.
    task automatic clear_table();
        for (int i = 0; i < ENTRIES; i++)
            if (tbl_valid[i])
                send_request(OP_DELETE, tbl_key[i], tbl_owner[i]);
        wait_drained();
    endtask

    task automatic test_directed_cases();
        logic [KEY_W-1:0] key_b;
        logic [KEY_W-1:0] key_miss;
        key_b = 64'h5A5A_0F0F_C3C3_9696;
        key_miss = 64'hA5A5_F0F0_3C3C_6969;
        send_request(OP_CREATE, '0, CLIENT_LOW);
        send_request(OP_CREATE, KEY_ALL_ONES, CLIENT_HIGH);
        send_request(OP_CREATE, KEY_ALL_ONES, CLIENT_LOW);
        send_request(OP_CREATE, key_b, CLIENT_LOW);
        send_request(OP_LOCK, KEY_ALL_ONES, CLIENT_LOW);
        send_request(OP_LOCK, KEY_ALL_ONES, CLIENT_LOW);
        send_request(OP_LOCK, key_b, CLIENT_HIGH);
        send_request(OP_LOCK, key_miss, CLIENT_LOW);
        send_request(OP_LOCK, key_b, CLIENT_LOW);
        send_request(OP_PERM, KEY_ALL_ONES, CLIENT_HIGH);
        send_request(OP_PERM, KEY_ALL_ONES, CLIENT_LOW);
        send_request(OP_PERM, key_miss, CLIENT_LOW);
        send_request(OP_PERM, '0, CLIENT_LOW);
        send_request(OP_SEND, KEY_ALL_ONES, CLIENT_HIGH);
        send_request(OP_SEND, KEY_ALL_ONES, CLIENT_LOW);
        send_request(OP_DELETE, KEY_ALL_ONES, CLIENT_HIGH);
        send_request(OP_UNLOCK, KEY_ALL_ONES, CLIENT_HIGH);
        send_request(OP_UNLOCK, KEY_ALL_ONES, CLIENT_LOW);
        send_request(OP_UNLOCK, KEY_ALL_ONES, CLIENT_LOW);
        send_request(OP_UNLOCK, key_miss, CLIENT_LOW);
        send_request(OP_SEND, KEY_ALL_ONES, CLIENT_LOW);
        send_request(OP_DELETE, KEY_ALL_ONES, CLIENT_HIGH);
        send_request(OP_DELETE, KEY_ALL_ONES, CLIENT_HIGH);
        send_request(OP_SPARE_A, key_b, CLIENT_HIGH);
        send_request(OP_SPARE_B, key_miss, CLIENT_LOW);
        wait_drained();
    endtask

    task automatic test_table_full();
        logic [KEY_W-1:0] key;
        clear_table();
        // Fill with fresh keys; after deletes the bench model reuses the lowest free slot.
        while (tbl_used < ENTRIES)
        begin
            key = {$urandom, $urandom} | KEY_ONE;
            send_request(OP_CREATE, key, pick_client());
        end
        send_request(OP_CREATE, {$urandom, $urandom} | KEY_ONE, CLIENT_HIGH);
        send_request(OP_CREATE, tbl_key[3], CLIENT_LOW);
        send_request(OP_DELETE, tbl_key[5], CLIENT_LOW);
        send_request(OP_CREATE, KEY_ONE, CLIENT_LOW);
        send_request(OP_LOCK, tbl_key[7], CLIENT_HIGH);
        send_request(OP_LOCK, tbl_key[8], CLIENT_LOW);
        send_request(OP_DELETE, tbl_key[7], CLIENT_LOW);
        send_request(OP_SEND, tbl_key[7], CLIENT_HIGH);
        wait_drained();
        clear_table();
    endtask

    // One create-lock-use-unlock-delete sequence, with steps dropped or
    // taken over by another client now and then.
    task automatic run_lifecycle();
        logic [KEY_W-1:0]    key;
        logic [CLIENT_W-1:0] client;
        logic [OPCODE_W-1:0] steps [6];
        steps = '{OP_CREATE, OP_LOCK, OP_PERM, OP_SEND, OP_UNLOCK, OP_DELETE};
        key = name_pool[$urandom_range(0, NAME_POOL - 1)];
        client = client_pool[$urandom_range(0, CLIENT_POOL - 1)];
        foreach (steps[i])
        begin
            if ($urandom_range(0, 9) < 2)
                continue;
            if (steps[i] == OP_DELETE && $urandom_range(0, 9) < 4)
                continue;
            if ($urandom_range(0, 9) < 2)
                send_request(steps[i], key, pick_client());
            else
                send_request(steps[i], key, client);
        end
    endtask

    task automatic send_noise();
        int slot;
        logic [OPCODE_W-1:0] op;
        slot = pick_locked_slot();
        if (slot >= 0 && $urandom_range(0, 99) < 40)
        begin
            // Mostly free a held lock for other clients; else send or delete on it.
            if ($urandom_range(0, 9) < 8)
                send_request(OP_UNLOCK, tbl_key[slot], tbl_owner[slot]);
            else
                send_request($urandom_range(0, 1) ? OP_SEND : OP_DELETE,
                             tbl_key[slot], pick_client());
            return;
        end
        if ($urandom_range(0, 99) < 4)
            op = $urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B;
        else
            op = OPCODE_W'($urandom_range(OP_CREATE, OP_SEND));
        send_request(op, pick_key(), pick_client());
    endtask

    task automatic test_random_traffic();
        int next_phase;
        next_phase = sent_count + 150;
        while (sent_count < TARGET_ITEMS)
        begin
            if (sent_count >= next_phase)
            begin
                next_phase = sent_count + $urandom_range(80, 200);
                if ($urandom_range(0, 3) == 0)
                    wait_drained();
                gaps_on = ($urandom_range(0, 2) != 0);
            end
            if ($urandom_range(0, 9) < 7)
                run_lifecycle();
            else
                send_noise();
        end
        gaps_on = 1'b1;
    endtask

    // Receiver: random stalls, a few long ones, none while gaps are off.
    initial
    begin : drive_ready
        int hold;
        hold = 0;
        rsp_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (!gaps_on)
                rsp_if.ready <= 1'b1;
            else if (hold > 0)
            begin
                rsp_if.ready <= 1'b0;
                hold--;
            end
            else if ($urandom_range(0, 59) == 0)
            begin
                hold = $urandom_range(20, 100);
                rsp_if.ready <= 1'b0;
            end
            else
                rsp_if.ready <= ($urandom_range(0, 3) != 0);
        end
    end

    initial
    begin : check_responses
        lock_answer_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_if.valid && rsp_if.ready)
            begin
                checked_count++;
                status_hits[rsp_if.status]++;
                if (pending_answers.size() == 0)
                    report_mismatch("response transfer with no request outstanding");
                else
                begin
                    want = pending_answers.pop_front();
                    if (rsp_if.status !== want.status)
                        report_mismatch($sformatf("op %0d: status %0d, expected %0d",
                                                  want.op, rsp_if.status, want.status));
                    if (rsp_if.permitted !== want.permitted)
                        report_mismatch($sformatf("op %0d: permitted %0b, expected %0b",
                                                  want.op, rsp_if.permitted,
                                                  want.permitted));
                    if (rsp_if.entry_count !== want.entry_count)
                        report_mismatch($sformatf("op %0d: entry_count %0d, expected %0d",
                                                  want.op, rsp_if.entry_count,
                                                  want.entry_count));
                end
            end
        end
    end

    initial
    begin : run_tests
        string seen;
        rst_n = 1'b0;
        gaps_on = 1'b1;
        req_if.valid = 1'b0;
        req_if.opcode = OP_CREATE;
        req_if.name_key = '0;
        req_if.client_id = '0;
        sent_count = 0;
        checked_count = 0;
        mismatch_count = 0;
        tbl_used = 0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            tbl_valid[i] = 1'b0;
            tbl_locked[i] = 1'b0;
            tbl_key[i] = '0;
            tbl_owner[i] = '0;
        end
        for (int i = 0; i < 16; i++)
            status_hits[i] = 0;
        name_pool[0] = KEY_ALL_ONES;
        name_pool[1] = KEY_ONE;
        for (int i = 2; i < NAME_POOL; i++)
            name_pool[i] = {$urandom, $urandom} | KEY_ONE;
        client_pool[0] = CLIENT_LOW;
        client_pool[1] = CLIENT_HIGH;
        client_pool[2] = CLIENT_W'($urandom);
        client_pool[3] = CLIENT_W'($urandom);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_table_full();
        test_random_traffic();

        wait_drained();
        repeat (LATENCY + 10) @(posedge clk);

        seen = "";
        for (int i = ST_OK; i <= ST_NOT_OWNER; i++)
            seen = {seen, $sformatf(" %0d:%0d", i, status_hits[i])};
        $display("Run covered %0d requests and %0d checked responses, %0d mismatches",
                 sent_count, checked_count, mismatch_count);
        $display("Responses per status code:%s", seen);
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/nlt_pkg.sv
hdl/nlt_req_if.sv
hdl/nlt_rsp_if.sv
hdl/nlt_cell.sv
hdl/nlt_ctrl.sv
hdl/named_lock_table.sv
test/tb_named_lock_table.sv
